// ===== sv/assert_macros.svh =====
// Assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/fcba_pkg.sv =====
`default_nettype none
package fcba_pkg;

  localparam int CMD_W    = 3;
  localparam int NAME_W   = 40;
  localparam int BLK_W    = 8;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 8;

  localparam logic [CMD_W-1:0] CMD_FORMAT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CREATE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;
  localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd6;

  localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EXISTS   = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DIRFULL  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] STS_DISKFULL = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NOBLOCK  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd6;

  localparam logic [CFG_W-1:0] CFG_RESET    = 8'd14;
  localparam logic [CFG_W-1:0] MIN_DATA_BLK = 8'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_DISPATCH,
    ST_FORMAT,
    ST_APP_RD,
    ST_APP_POP,
    ST_APP_HEAD,
    ST_APP_WALK,
    ST_CH_WALK,
    ST_DEL_LINK,
    ST_DEL_FREE,
    ST_FINISH
  } state_e;

endpackage
`default_nettype wire

// ===== sv/fcba_if.sv =====
`default_nettype none
interface fcba_req_if;
  logic                       valid;
  logic                       ready;
  logic [fcba_pkg::CMD_W-1:0]  command;
  logic [fcba_pkg::NAME_W-1:0] file_name;
  logic [fcba_pkg::BLK_W-1:0]  block_number;
  modport source (output valid, command, file_name, block_number, input ready);
  modport sink   (input valid, command, file_name, block_number, output ready);
endinterface

interface fcba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fcba_pkg::STATUS_W-1:0] status;
  logic [fcba_pkg::BLK_W-1:0]    result_block;
  modport source (output valid, status, result_block, input ready);
  modport sink   (input valid, status, result_block, output ready);
endinterface

interface fcba_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [fcba_pkg::CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/fcba_ram.sv =====
`default_nettype none
module fcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/fat_chain_block_allocator_top.sv =====
// File allocation table with a small directory.
// req_i: one command transaction (command, file_name, block_number); taken only
//   while idle, one command in flight at a time.
// rsp_o: exactly one transaction (status, result_block) per command, held
//   until rsp_o.ready; the next command is taken while a response waits.
// cfg_i: first_data_block write, always ready; write only while idle.
// Sequencing from accept to response valid:
//   format: one table write per cycle over every block.
//   others: directory scan, a read state and a compare state per slot
//   (DIR_ENTRIES slots, stops on a hit), then chain walks (append, delete,
//   next), one next-table read per cycle through the single table read port.
// Reset: no free blocks, directory empty, first_data_block = 14. The next
//   table holds nothing valid until the first format.
// A stalled response only delays the return to idle; nothing is dropped.
`default_nettype none
module fat_chain_block_allocator_top #(
  parameter int BLOCK_COUNT = 256,
  parameter int DIR_ENTRIES = 16,
  parameter int NAME_BYTES  = 5
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fcba_req_if.sink   req_i,
  fcba_rsp_if.source rsp_o,
  fcba_cfg_if.sink   cfg_i
);
  import fcba_pkg::*;
  `include "assert_macros.svh"

  localparam int BW  = $clog2(BLOCK_COUNT);
  localparam int CW  = (BW > BLK_W) ? BW : BLK_W;
  localparam int DW  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
  localparam int SW  = (NAME_BYTES * 8 < NAME_W) ? NAME_BYTES * 8 : NAME_W;
  localparam int DRW = SW + BW;

  state_e state_q, state_d;

  logic [CMD_W-1:0]     cmd_q, cmd_d;
  logic [SW-1:0]        name_q, name_d;
  logic [BLK_W-1:0]     blk_q, blk_d;
  logic [CFG_W-1:0]     cfg_q;
  logic [BW-1:0]        free_head_q, free_head_d;
  logic [DIR_ENTRIES-1:0] used_q, used_d;
  logic [DW-1:0]        idx_q, idx_d;
  logic                 found_q, found_d;
  logic [DW-1:0]        ent_q, ent_d;
  logic [BW-1:0]        head_q, head_d;
  logic                 slot_ok_q, slot_ok_d;
  logic [DW-1:0]        slot_q, slot_d;
  logic [BW-1:0]        cur_q, cur_d;
  logic [BW-1:0]        prev_q, prev_d;
  logic [BW-1:0]        nxt_q, nxt_d;
  logic [BW:0]          steps_q, steps_d;
  logic [STATUS_W-1:0]  fin_status_q, fin_status_d;
  logic [BLK_W-1:0]     fin_block_q, fin_block_d;
  logic                 rsp_valid_q, rsp_valid_d;
  logic [STATUS_W-1:0]  rsp_status_q, rsp_status_d;
  logic [BLK_W-1:0]     rsp_block_q, rsp_block_d;

  logic          nt_we;
  logic [BW-1:0] nt_waddr, nt_wdata, nt_raddr, nt_rdata;
  logic          dir_we;
  logic [DW-1:0] dir_waddr, dir_raddr;
  logic [DRW-1:0] dir_wdata, dir_rdata;

  logic [CFG_W-1:0] fd;
  logic             fd_in_range;
  logic             req_fire;
  logic             cmd_scans;
  logic             hit;
  logic             scan_last;
  logic             walk_end;
  logic             cur_is_blk;

  fcba_ram #(.WIDTH(BW), .DEPTH(BLOCK_COUNT)) u_next_tbl (
    .clk_i   (clk_i),
    .we_i    (nt_we),
    .waddr_i (nt_waddr),
    .wdata_i (nt_wdata),
    .raddr_i (nt_raddr),
    .rdata_o (nt_rdata)
  );

  fcba_ram #(.WIDTH(DRW), .DEPTH(DIR_ENTRIES)) u_dir (
    .clk_i   (clk_i),
    .we_i    (dir_we),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  assign req_i.ready  = (state_q == ST_IDLE);
  assign req_fire     = req_i.valid && req_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = rsp_status_q;
  assign rsp_o.result_block = rsp_block_q;

  assign fd          = (cfg_q < MIN_DATA_BLK) ? MIN_DATA_BLK : cfg_q;
  assign fd_in_range = 32'(fd) < 32'(BLOCK_COUNT);
  assign cmd_scans   = (cmd_q >= CMD_CREATE) && (cmd_q <= CMD_FIRST);
  assign hit         = used_q[idx_q] && (dir_rdata[DRW-1:BW] == name_q);
  assign scan_last   = (idx_q == DW'(DIR_ENTRIES - 1));
  assign walk_end    = (steps_q == (BW+1)'(BLOCK_COUNT));
  assign cur_is_blk  = (CW'(cur_q) == CW'(blk_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_i.command == CMD_FORMAT) begin
            state_d = ST_FORMAT;
          end else if (req_i.command >= CMD_CREATE && req_i.command <= CMD_FIRST) begin
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_SCAN_RD:  state_d = ST_SCAN_CMP;
      ST_SCAN_CMP: state_d = (hit || scan_last) ? ST_DISPATCH : ST_SCAN_RD;
      ST_DISPATCH: begin
        state_d = ST_FINISH;
        if (found_q && cmd_q == CMD_APPEND && free_head_q != '0) begin
          state_d = ST_APP_RD;
        end else if (found_q && (cmd_q == CMD_DELETE || cmd_q == CMD_NEXT) &&
                     head_q != '0 && blk_q != '0) begin
          state_d = ST_CH_WALK;
        end
      end
      ST_FORMAT:   state_d = (cur_q == BW'(BLOCK_COUNT - 1)) ? ST_FINISH : ST_FORMAT;
      ST_APP_RD:   state_d = ST_APP_POP;
      ST_APP_POP:  state_d = ST_APP_HEAD;
      ST_APP_HEAD: state_d = (head_q == '0) ? ST_FINISH : ST_APP_WALK;
      ST_APP_WALK: state_d = (nt_rdata == '0 || walk_end) ? ST_FINISH : ST_APP_WALK;
      ST_CH_WALK: begin
        if (cur_q == '0 || walk_end) begin
          state_d = ST_FINISH;
        end else if (cur_is_blk) begin
          state_d = (cmd_q == CMD_DELETE) ? ST_DEL_LINK : ST_FINISH;
        end
      end
      ST_DEL_LINK: state_d = ST_DEL_FREE;
      ST_DEL_FREE: state_d = ST_FINISH;
      ST_FINISH:   state_d = (!rsp_valid_q || rsp_o.ready) ? ST_IDLE : ST_FINISH;
      default:     state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d        = cmd_q;
    name_d       = name_q;
    blk_d        = blk_q;
    free_head_d  = free_head_q;
    used_d       = used_q;
    idx_d        = idx_q;
    found_d      = found_q;
    ent_d        = ent_q;
    head_d       = head_q;
    slot_ok_d    = slot_ok_q;
    slot_d       = slot_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    nxt_d        = nxt_q;
    steps_d      = steps_q;
    fin_status_d = fin_status_q;
    fin_block_d  = fin_block_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_block_d  = rsp_block_q;
    nt_we        = 1'b0;
    nt_waddr     = cur_q;
    nt_wdata     = '0;
    nt_raddr     = cur_q;
    dir_we       = 1'b0;
    dir_waddr    = ent_q;
    dir_wdata    = {name_q, {BW{1'b0}}};
    dir_raddr    = idx_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          cmd_d        = req_i.command;
          name_d       = req_i.file_name[SW-1:0];
          blk_d        = req_i.block_number;
          idx_d        = '0;
          found_d      = 1'b0;
          slot_ok_d    = 1'b0;
          cur_d        = '0;
          fin_status_d = STS_OK;
          fin_block_d  = '0;
        end
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          found_d = 1'b1;
          ent_d   = idx_q;
          head_d  = dir_rdata[BW-1:0];
        end
        if (!used_q[idx_q] && !slot_ok_q) begin
          slot_ok_d = 1'b1;
          slot_d    = idx_q;
        end
        idx_d = idx_q + DW'(1);
      end
      ST_DISPATCH: begin
        if (cmd_q == CMD_CREATE) begin
          if (found_q) begin
            fin_status_d = STS_EXISTS;
          end else if (!slot_ok_q) begin
            fin_status_d = STS_DIRFULL;
          end else begin
            dir_we          = 1'b1;
            dir_waddr       = slot_q;
            used_d[slot_q]  = 1'b1;
          end
        end else if (cmd_scans && !found_q) begin
          fin_status_d = STS_NOTFOUND;
        end else begin
          case (cmd_q)
            CMD_REMOVE: used_d[ent_q] = 1'b0;
            CMD_APPEND: begin
              if (free_head_q == '0) fin_status_d = STS_DISKFULL;
            end
            CMD_DELETE, CMD_NEXT: begin
              if (head_q == '0) begin
                fin_status_d = STS_EMPTY;
              end else if (blk_q == '0) begin
                fin_status_d = STS_NOBLOCK;
              end else begin
                nt_raddr = head_q;
                cur_d    = head_q;
                steps_d  = '0;
              end
            end
            CMD_FIRST: fin_block_d = BLK_W'(head_q);
            default: ;
          endcase
        end
      end
      ST_FORMAT: begin
        nt_we    = 1'b1;
        nt_waddr = cur_q;
        nt_wdata = (32'(cur_q) >= 32'(fd) && cur_q != BW'(BLOCK_COUNT - 1)) ?
                   cur_q + BW'(1) : '0;
        cur_d    = cur_q + BW'(1);
        if (cur_q == BW'(BLOCK_COUNT - 1)) begin
          free_head_d = fd_in_range ? BW'(fd) : '0;
          used_d      = '0;
        end
      end
      ST_APP_RD: begin
        nt_raddr = free_head_q;
        nxt_d    = free_head_q;
      end
      ST_APP_POP: begin
        // nxt_q holds the popped block
        free_head_d = nt_rdata;
        nt_we       = 1'b1;
        nt_waddr    = nxt_q;
        nt_wdata    = '0;
        fin_block_d = BLK_W'(nxt_q);
      end
      ST_APP_HEAD: begin
        if (head_q == '0) begin
          dir_we    = 1'b1;
          dir_waddr = ent_q;
          dir_wdata = {name_q, nxt_q};
        end else begin
          nt_raddr = head_q;
          cur_d    = head_q;
          steps_d  = '0;
        end
      end
      ST_APP_WALK: begin
        // nt_rdata = next[cur_q]
        if (nt_rdata == '0 || walk_end) begin
          nt_we    = 1'b1;
          nt_waddr = cur_q;
          nt_wdata = nxt_q;
        end else begin
          cur_d    = nt_rdata;
          nt_raddr = nt_rdata;
          steps_d  = steps_q + (BW+1)'(1);
        end
      end
      ST_CH_WALK: begin
        if (cur_q == '0 || walk_end) begin
          fin_status_d = STS_NOBLOCK;
        end else if (cur_is_blk) begin
          nxt_d = nt_rdata;
          if (cmd_q == CMD_NEXT) fin_block_d = BLK_W'(nt_rdata);
        end else begin
          prev_d   = cur_q;
          cur_d    = nt_rdata;
          nt_raddr = nt_rdata;
          steps_d  = steps_q + (BW+1)'(1);
        end
      end
      ST_DEL_LINK: begin
        if (steps_q == '0) begin
          dir_we    = 1'b1;
          dir_waddr = ent_q;
          dir_wdata = {name_q, nxt_q};
        end else begin
          nt_we    = 1'b1;
          nt_waddr = prev_q;
          nt_wdata = nxt_q;
        end
      end
      ST_DEL_FREE: begin
        nt_we       = 1'b1;
        nt_waddr    = cur_q;
        nt_wdata    = free_head_q;
        free_head_d = cur_q;
      end
      ST_FINISH: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = fin_status_q;
          rsp_block_d  = fin_block_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_q       <= CFG_RESET;
      free_head_q <= '0;
      used_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      if (cfg_i.valid && cfg_i.ready) cfg_q <= cfg_i.data;
      free_head_q <= free_head_d;
      used_q      <= used_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    name_q       <= name_d;
    blk_q        <= blk_d;
    idx_q        <= idx_d;
    found_q      <= found_d;
    ent_q        <= ent_d;
    head_q       <= head_d;
    slot_ok_q    <= slot_ok_d;
    slot_q       <= slot_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    nxt_q        <= nxt_d;
    steps_q      <= steps_d;
    fin_status_q <= fin_status_d;
    fin_block_q  <= fin_block_d;
    rsp_status_q <= rsp_status_d;
    rsp_block_q  <= rsp_block_d;
  end

  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, req_fire, !req_i.ready)
  `ASSERT_IMPLY(a_dir_write_busy, clk_i, rst_ni, dir_we, state_q != ST_IDLE)
  `ASSERT_IMPLY(a_table_write_busy, clk_i, rst_ni, nt_we, state_q != ST_IDLE)
  `ASSERT_IMPLY(a_walk_bounded, clk_i, rst_ni, state_q == ST_APP_WALK || state_q == ST_CH_WALK, steps_q <= (BW+1)'(BLOCK_COUNT))
endmodule
`default_nettype wire
